[sv/tbdv_pkg.sv]
// shared types and constants for the triangle barycentric dual volume pipeline
// no dependencies
`timescale 1ns / 1ps

package tbdv_pkg;

  localparam int COORD_W = 24;
  localparam int LEN_W = 26;
  localparam int AREA_W = 40;
  localparam int FRAC_BITS_DEF = 16;
  // bits resolved per stage in the divide-by-three units
  localparam int DIV_CH = 8;
  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex0_x;
    logic signed [COORD_W-1:0] vertex0_y;
    logic signed [COORD_W-1:0] vertex0_z;
    logic signed [COORD_W-1:0] vertex1_x;
    logic signed [COORD_W-1:0] vertex1_y;
    logic signed [COORD_W-1:0] vertex1_z;
    logic signed [COORD_W-1:0] vertex2_x;
    logic signed [COORD_W-1:0] vertex2_y;
    logic signed [COORD_W-1:0] vertex2_z;
  } tbdv_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [LEN_W-1:0]          edge_len0;
    logic [LEN_W-1:0]          edge_len1;
    logic [LEN_W-1:0]          edge_len2;
    logic [LEN_W-1:0]          dual_len0;
    logic [LEN_W-1:0]          dual_len1;
    logic [LEN_W-1:0]          dual_len2;
    logic [AREA_W-1:0]         cell_area0;
    logic [AREA_W-1:0]         cell_area1;
    logic [AREA_W-1:0]         cell_area2;
  } tbdv_out_t;

endpackage

[sv/triangle_barycentric_dual_volumes.sv]
// throughput: one triangle per cycle while out_stall is low
// the 50-stage area square root sets the depth
// every stage holds a valid bit and fills bubbles, so input flows while the output waits
// reset: synchronous, active low, clears the valid bits only
// depends on tbdv_pkg, tbdv_isqrt, tbdv_div3
`timescale 1ns / 1ps

module triangle_barycentric_dual_volumes
  import tbdv_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tbdv_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output tbdv_out_t out_data
);

  localparam int SQ_FIRST = 8;
  localparam int SQ_LAST  = SQ_FIRST + 49;
  localparam int WQ       = 49 - FRAC_BITS;
  localparam int ND       = (WQ + DIV_CH - 1) / DIV_CH;
  localparam int NDD      = (25 + DIV_CH - 1) / DIV_CH;
  localparam int L        = SQ_LAST + ND;
  // offset keeps the center dividend positive; removed again by flipping bit 23
  localparam logic signed [25:0] CTR_OFFS = 26'sd25165825;
  localparam logic [COORD_W-1:0] CTR_FLIP = 24'h800000;

  logic [L:1] vld_r;
  logic [L:1] rdy;

  logic signed [23:0] p [3][3];

  logic [25:0]        u_r   [3];
  logic signed [24:0] e_r   [3][3];
  logic signed [25:0] d_r   [3][3];
  logic [48:0]        sqe_r [3][3];
  logic [49:0]        sqd_r [3][3];
  logic signed [49:0] crs_r [6];
  logic [49:0]        se_r  [3];
  logic [51:0]        sd_r  [3];
  logic signed [49:0] n_r   [3];
  logic [48:0]        nm_r  [3];
  logic [47:0]        hh_r  [3];
  logic [48:0]        hl_r  [3];
  logic [49:0]        ll_r  [3];
  logic [97:0]        sq_r  [3];
  logic [99:0]        nsq_r;

  logic [25:0] center_q  [3];
  logic [24:0] edge_root [3];
  logic [25:0] dual_root [3];
  logic [24:0] dual_q    [3];
  logic [49:0] area_root;
  logic [WQ-1:0] area_q;
  logic [63:0] area_w;
  logic [AREA_W-1:0] area_sat;

  assign p[0][0] = in_data.vertex0_x;
  assign p[0][1] = in_data.vertex0_y;
  assign p[0][2] = in_data.vertex0_z;
  assign p[1][0] = in_data.vertex1_x;
  assign p[1][1] = in_data.vertex1_y;
  assign p[1][2] = in_data.vertex1_z;
  assign p[2][0] = in_data.vertex2_x;
  assign p[2][1] = in_data.vertex2_y;
  assign p[2][2] = in_data.vertex2_z;

  // a stage may load when it is empty or its contents move on
  always_comb begin
    rdy[L] = !vld_r[L] || !out_stall;
    for (int k = L - 1; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall  = !rdy[1];
  assign out_valid = vld_r[L];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[1]) begin
        vld_r[1] <= in_valid;
      end
      for (int k = 2; k <= L; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // stage 1: center dividend, edges, scaled dual edges
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int c = 0; c < 3; c++) begin
        u_r[c] <= 26'(26'(p[0][c]) + 26'(p[1][c]) + 26'(p[2][c]) + CTR_OFFS);
        e_r[0][c] <= 25'(p[2][c]) - 25'(p[1][c]);
        e_r[1][c] <= 25'(p[0][c]) - 25'(p[2][c]);
        e_r[2][c] <= 25'(p[1][c]) - 25'(p[0][c]);
        for (int k = 0; k < 3; k++) begin
          d_r[k][c] <= 26'(p[k][c]) + 26'(p[k][c]) - 26'(p[(k+1)%3][c])
                       - 26'(p[(k+2)%3][c]);
        end
      end
    end
  end

  // stage 2: squares and cross product terms
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 3; c++) begin
          sqe_r[k][c] <= 49'(e_r[k][c] * e_r[k][c]);
          sqd_r[k][c] <= 50'(d_r[k][c] * d_r[k][c]);
        end
      end
      crs_r[0] <= 50'(e_r[1][1] * e_r[2][2]);
      crs_r[1] <= 50'(e_r[1][2] * e_r[2][1]);
      crs_r[2] <= 50'(e_r[1][2] * e_r[2][0]);
      crs_r[3] <= 50'(e_r[1][0] * e_r[2][2]);
      crs_r[4] <= 50'(e_r[1][0] * e_r[2][1]);
      crs_r[5] <= 50'(e_r[1][1] * e_r[2][0]);
    end
  end

  // stage 3: squared lengths, doubled area vector
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int k = 0; k < 3; k++) begin
        se_r[k] <= 50'(sqe_r[k][0]) + 50'(sqe_r[k][1]) + 50'(sqe_r[k][2]);
        sd_r[k] <= 52'(sqd_r[k][0]) + 52'(sqd_r[k][1]) + 52'(sqd_r[k][2]);
        n_r[k]  <= crs_r[2*k] - crs_r[2*k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int c = 0; c < 3; c++) begin
        nm_r[c] <= n_r[c][49] ? 49'(-n_r[c]) : 49'(n_r[c]);
      end
    end
  end

  // stages 5 to 7: 49-bit squares split into partial products, then summed
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int c = 0; c < 3; c++) begin
        hh_r[c] <= nm_r[c][48:25] * nm_r[c][48:25];
        hl_r[c] <= nm_r[c][48:25] * nm_r[c][24:0];
        ll_r[c] <= nm_r[c][24:0] * nm_r[c][24:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int c = 0; c < 3; c++) begin
        sq_r[c] <= {hh_r[c], 50'b0} + {23'b0, hl_r[c], 26'b0} + 98'(ll_r[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      nsq_r <= 100'(sq_r[0]) + 100'(sq_r[1]) + 100'(sq_r[2]);
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    tbdv_div3 #(.W(26), .DEPTH(L - 1)) u_center (
      .clk (clk),
      .en  (rdy[L:2]),
      .x   (u_r[k]),
      .q   (center_q[k])
    );

    tbdv_isqrt #(.VW(50), .DEPTH(L - 3)) u_edge (
      .clk  (clk),
      .en   (rdy[L:4]),
      .val  (se_r[k]),
      .root (edge_root[k])
    );

    // floor(sqrt(sd) / 6) equals the root of floor(sd / 36)
    tbdv_isqrt #(.VW(52), .DEPTH(L - 3 - NDD)) u_dual (
      .clk  (clk),
      .en   (rdy[L-NDD:4]),
      .val  (sd_r[k]),
      .root (dual_root[k])
    );

    tbdv_div3 #(.W(25), .DEPTH(NDD)) u_dual_div (
      .clk (clk),
      .en  (rdy[L:L-NDD+1]),
      .x   (dual_root[k][25:1]),
      .q   (dual_q[k])
    );
  end

  tbdv_isqrt #(.VW(100), .DEPTH(SQ_LAST - SQ_FIRST + 1)) u_area (
    .clk  (clk),
    .en   (rdy[SQ_LAST:SQ_FIRST]),
    .val  (nsq_r),
    .root (area_root)
  );

  tbdv_div3 #(.W(WQ), .DEPTH(ND)) u_area_div (
    .clk (clk),
    .en  (rdy[L:SQ_LAST+1]),
    .x   (area_root[49:FRAC_BITS+1]),
    .q   (area_q)
  );

  assign area_w   = 64'(area_q);
  assign area_sat = (area_w > 64'(AREA_MAX)) ? AREA_MAX : area_w[AREA_W-1:0];

  always_comb begin
    out_data.center_x   = center_q[0][23:0] ^ CTR_FLIP;
    out_data.center_y   = center_q[1][23:0] ^ CTR_FLIP;
    out_data.center_z   = center_q[2][23:0] ^ CTR_FLIP;
    out_data.edge_len0  = LEN_W'(edge_root[0]);
    out_data.edge_len1  = LEN_W'(edge_root[1]);
    out_data.edge_len2  = LEN_W'(edge_root[2]);
    out_data.dual_len0  = LEN_W'(dual_q[0]);
    out_data.dual_len1  = LEN_W'(dual_q[1]);
    out_data.dual_len2  = LEN_W'(dual_q[2]);
    out_data.cell_area0 = area_sat;
    out_data.cell_area1 = area_sat;
    out_data.cell_area2 = area_sat;
  end

  a_sink_ready_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while the sink takes results");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r))
    else $error("input stalled with a bubble in the pipeline");

  a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[L-1] && rdy[L]) |=> out_valid)
    else $error("request lost entering the output stage");

  a_triangle_inequality: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (27'(out_data.edge_len0)
                   <= 27'(out_data.edge_len1) + 27'(out_data.edge_len2) + 27'd1))
    else $error("edge lengths break the triangle inequality");

endmodule

[sv/tbdv_isqrt.sv]
// pipelined integer square root, one root bit per stage, then root-only hold stages
// no dependencies
`timescale 1ns / 1ps

module tbdv_isqrt #(
  parameter int VW = 50,
  parameter int DEPTH = 25
) (
  input  logic              clk,
  input  logic [DEPTH-1:0]  en,
  input  logic [VW-1:0]     val,
  output logic [VW/2-1:0]   root
);

  localparam int RW = VW / 2;

  logic [RW+1:0] rem_r  [RW];
  logic [VW-1:0] val_r  [RW];
  logic [RW-1:0] root_r [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_stage
    if (k < RW) begin : g_step
      logic [RW+1:0] rem_in;
      logic [RW+1:0] rem_sh;
      logic [RW+1:0] trial;
      logic [RW-1:0] root_in;
      logic [VW-1:0] val_in;

      if (k == 0) begin : g_first
        assign rem_in  = '0;
        assign root_in = '0;
        assign val_in  = val;
      end else begin : g_next
        assign rem_in  = rem_r[k-1];
        assign root_in = root_r[k-1];
        assign val_in  = val_r[k-1];
      end

      // remainder stays below 2^RW before the shift
      assign rem_sh = {rem_in[RW-1:0], val_in[VW-1:VW-2]};
      assign trial  = {root_in, 2'b01};

      always_ff @(posedge clk) begin
        if (en[k]) begin
          if (rem_sh >= trial) begin
            rem_r[k]  <= rem_sh - trial;
            root_r[k] <= {root_in[RW-2:0], 1'b1};
          end else begin
            rem_r[k]  <= rem_sh;
            root_r[k] <= {root_in[RW-2:0], 1'b0};
          end
          val_r[k] <= {val_in[VW-3:0], 2'b00};
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (en[k]) begin
          root_r[k] <= root_r[k-1];
        end
      end
    end
  end

  assign root = root_r[DEPTH-1];

endmodule

[sv/tbdv_div3.sv]
// pipelined floor division by three, a fixed chunk of dividend bits per stage
// depends on tbdv_pkg
`timescale 1ns / 1ps

module tbdv_div3
  import tbdv_pkg::*;
#(
  parameter int W = 26,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic [DEPTH-1:0] en,
  input  logic [W-1:0]     x,
  output logic [W-1:0]     q
);

  localparam int NS = (W + DIV_CH - 1) / DIV_CH;
  localparam int WP = NS * DIV_CH;
  localparam logic [2:0] DIVISOR = 3'd3;

  logic [1:0]    rem_r [NS];
  logic [WP-1:0] x_r   [NS];
  logic [WP-1:0] q_r   [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_stage
    if (k < NS) begin : g_step
      logic [1:0]    rem_in;
      logic [WP-1:0] x_in;
      logic [WP-1:0] q_in;
      logic [1:0]    rem_nxt;
      logic [WP-1:0] x_nxt;
      logic [WP-1:0] q_nxt;

      if (k == 0) begin : g_first
        assign rem_in = '0;
        assign x_in   = WP'(x);
        assign q_in   = '0;
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign x_in   = x_r[k-1];
        assign q_in   = q_r[k-1];
      end

      always_comb begin
        logic [1:0]    r;
        logic [2:0]    t;
        logic [WP-1:0] xx;
        logic [WP-1:0] qq;
        r  = rem_in;
        xx = x_in;
        qq = q_in;
        for (int j = 0; j < DIV_CH; j++) begin
          t  = {r, xx[WP-1]};
          xx = {xx[WP-2:0], 1'b0};
          if (t >= DIVISOR) begin
            t  = t - DIVISOR;
            qq = {qq[WP-2:0], 1'b1};
          end else begin
            qq = {qq[WP-2:0], 1'b0};
          end
          r = t[1:0];
        end
        rem_nxt = r;
        x_nxt   = xx;
        q_nxt   = qq;
      end

      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem_r[k] <= rem_nxt;
          x_r[k]   <= x_nxt;
          q_r[k]   <= q_nxt;
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (en[k]) begin
          q_r[k] <= q_r[k-1];
        end
      end
    end
  end

  assign q = q_r[DEPTH-1][W-1:0];

endmodule

[test/tbdv_checker.sv]
// checker for the triangle barycentric dual volume pipeline: predicts and compares results
// depends on tbdv_pkg; watches the request and result channels of the block
`timescale 1ns / 1ps

module tbdv_checker
  import tbdv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  tbdv_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  tbdv_out_t out_data,
  output int        fail_count,
  output int        pending
);

  tbdv_out_t expected_q[$];

  initial fail_count = 0;
  assign pending = expected_q.size();

  // bitwise square root, searching downward from bit top
  function automatic logic [63:0] int_sqrt(logic [127:0] v, int top);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = top; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] clip_len(logic [63:0] v);
    return (v > {{(64-LEN_W){1'b0}}, {LEN_W{1'b1}}}) ? {LEN_W{1'b1}} : v[LEN_W-1:0];
  endfunction

  function automatic tbdv_out_t predict_dual_cells(tbdv_in_t t);
    tbdv_out_t o;
    longint p[3][3];
    longint e[3][3];
    longint d[3][3];
    longint n[3];
    longint s, q;
    logic [63:0] se, sd, m, area;
    logic [127:0] nsq;
    logic [LEN_W-1:0] el[3];
    logic [LEN_W-1:0] dl[3];
    logic [COORD_W-1:0] ctr[3];
    p[0][0] = longint'(t.vertex0_x); p[0][1] = longint'(t.vertex0_y);
    p[0][2] = longint'(t.vertex0_z);
    p[1][0] = longint'(t.vertex1_x); p[1][1] = longint'(t.vertex1_y);
    p[1][2] = longint'(t.vertex1_z);
    p[2][0] = longint'(t.vertex2_x); p[2][1] = longint'(t.vertex2_y);
    p[2][2] = longint'(t.vertex2_z);
    for (int c = 0; c < 3; c++) begin
      s = p[0][c] + p[1][c] + p[2][c];
      // round to nearest: floor((s + 1) / 3)
      q = (s + 1) / 3;
      if (((s + 1) % 3 != 0) && (s + 1 < 0)) q = q - 1;
      ctr[c] = q[COORD_W-1:0];
      e[0][c] = p[2][c] - p[1][c];
      e[1][c] = p[0][c] - p[2][c];
      e[2][c] = p[1][c] - p[0][c];
      for (int k = 0; k < 3; k++) d[k][c] = 3 * p[k][c] - s;
    end
    for (int k = 0; k < 3; k++) begin
      se = 0;
      sd = 0;
      for (int c = 0; c < 3; c++) begin
        se += e[k][c] * e[k][c];
        sd += d[k][c] * d[k][c];
      end
      el[k] = clip_len(int_sqrt({64'd0, se}, 63));
      dl[k] = clip_len(int_sqrt({64'd0, sd / 36}, 63));
    end
    n[0] = e[1][1] * e[2][2] - e[1][2] * e[2][1];
    n[1] = e[1][2] * e[2][0] - e[1][0] * e[2][2];
    n[2] = e[1][0] * e[2][1] - e[1][1] * e[2][0];
    nsq = '0;
    for (int c = 0; c < 3; c++) begin
      m = (n[c] < 0) ? -n[c] : n[c];
      nsq += {64'd0, m} * {64'd0, m};
    end
    area = int_sqrt(nsq, 50) / (64'd6 << FRAC_BITS_DEF);
    if (area > {24'd0, AREA_MAX}) area = {24'd0, AREA_MAX};
    o.center_x = ctr[0]; o.center_y = ctr[1]; o.center_z = ctr[2];
    o.edge_len0 = el[0]; o.edge_len1 = el[1]; o.edge_len2 = el[2];
    o.dual_len0 = dl[0]; o.dual_len1 = dl[1]; o.dual_len2 = dl[2];
    o.cell_area0 = area[AREA_W-1:0];
    o.cell_area1 = area[AREA_W-1:0];
    o.cell_area2 = area[AREA_W-1:0];
    return o;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s got %h expected %h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report(what, got, want);
  endtask

  always @(posedge clk) begin
    tbdv_out_t w;
    if (rst_n && in_valid && !in_stall) expected_q.push_back(predict_dual_cells(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", out_data.cell_area0, 0);
      end else begin
        w = expected_q.pop_front();
        check_field("center_x", out_data.center_x, w.center_x);
        check_field("center_y", out_data.center_y, w.center_y);
        check_field("center_z", out_data.center_z, w.center_z);
        check_field("edge_len0", out_data.edge_len0, w.edge_len0);
        check_field("edge_len1", out_data.edge_len1, w.edge_len1);
        check_field("edge_len2", out_data.edge_len2, w.edge_len2);
        check_field("dual_len0", out_data.dual_len0, w.dual_len0);
        check_field("dual_len1", out_data.dual_len1, w.dual_len1);
        check_field("dual_len2", out_data.dual_len2, w.dual_len2);
        check_field("cell_area0", out_data.cell_area0, w.cell_area0);
        check_field("cell_area1", out_data.cell_area1, w.cell_area1);
        check_field("cell_area2", out_data.cell_area2, w.cell_area2);
      end
    end
  end

endmodule

[test/testbench.sv]
// top of the triangle barycentric dual volume testbench: clock, reset, triangle requests
// depends on tbdv_pkg, triangle_barycentric_dual_volumes and tbdv_checker
`timescale 1ns / 1ps

module testbench
  import tbdv_pkg::*;
();

  localparam int RANDOM_ITEMS = 1330;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [COORD_W-1:0] CMAX = 24'h7fffff;
  localparam logic [COORD_W-1:0] CMIN = 24'h800000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  tbdv_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  tbdv_out_t out_data;
  int        fail_count;
  int        pending;
  int        cycles;
  logic      in_took;
  logic      calm;

  triangle_barycentric_dual_volumes u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  tbdv_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    cycles = 0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    rst_n = 1'b0;
    calm = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_took <= in_valid && !in_stall;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (!rst_n || calm) out_stall <= 1'b0;
    else if ($urandom_range(0, 99) < 3) out_stall <= 1'b1;
    else if (out_stall) out_stall <= ($urandom_range(0, 99) < 85);
    else out_stall <= ($urandom_range(0, 99) < 25);
  end

  task automatic send_triangle(tbdv_in_t t);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    forever begin
      @(negedge clk);
      if (in_took) break;
    end
  endtask

  function automatic tbdv_in_t make_tri(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b,
                                        logic [COORD_W-1:0] c, logic [COORD_W-1:0] d,
                                        logic [COORD_W-1:0] e, logic [COORD_W-1:0] f,
                                        logic [COORD_W-1:0] g, logic [COORD_W-1:0] h,
                                        logic [COORD_W-1:0] i);
    return {a, b, c, d, e, f, g, h, i};
  endfunction

  function automatic logic [COORD_W-1:0] small_coord();
    return COORD_W'($signed($urandom_range(0, 8191)) - 4096);
  endfunction

  function automatic tbdv_in_t random_triangle();
    tbdv_in_t t;
    int kind;
    logic [7*32-1:0] rnd;
    kind = $urandom_range(0, 99);
    rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    t = rnd[$bits(tbdv_in_t)-1:0];
    if (kind >= 50 && kind < 75) begin
      t = make_tri(small_coord(), small_coord(), small_coord(), small_coord(),
                   small_coord(), small_coord(), small_coord(), small_coord(),
                   small_coord());
    end else if (kind >= 75 && kind < 85) begin
      // repeated vertex: zero-length edge
      t.vertex2_x = t.vertex0_x; t.vertex2_y = t.vertex0_y; t.vertex2_z = t.vertex0_z;
    end else if (kind >= 85 && kind < 92) begin
      // collinear: vertex 2 mirrors vertex 0 through vertex 1 (small coords avoid wrap)
      t = make_tri(small_coord(), small_coord(), small_coord(), small_coord(),
                   small_coord(), small_coord(), 0, 0, 0);
      t.vertex2_x = COORD_W'(2 * t.vertex1_x - t.vertex0_x);
      t.vertex2_y = COORD_W'(2 * t.vertex1_y - t.vertex0_y);
      t.vertex2_z = COORD_W'(2 * t.vertex1_z - t.vertex0_z);
    end else if (kind >= 92) begin
      t = make_tri($urandom_range(0, 1) ? CMAX : CMIN, $urandom_range(0, 1) ? CMAX : CMIN,
                   $urandom_range(0, 1) ? CMAX : CMIN, $urandom_range(0, 1) ? CMAX : CMIN,
                   $urandom_range(0, 1) ? CMAX : CMIN, $urandom_range(0, 1) ? CMAX : CMIN,
                   $urandom_range(0, 1) ? CMAX : CMIN, $urandom_range(0, 1) ? CMAX : CMIN,
                   $urandom_range(0, 1) ? CMAX : CMIN);
    end
    return t;
  endfunction

  initial begin
    int waited;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_triangle(make_tri(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    send_triangle(make_tri(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    send_triangle(make_tri(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN));
    send_triangle(make_tri(CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX));
    send_triangle(make_tri(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN));
    send_triangle(make_tri(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX));
    // unit right triangle in Q8.16
    send_triangle(make_tri(0, 0, 0, 24'h010000, 0, 0, 0, 24'h010000, 0));
    send_triangle(make_tri(0, 0, 0, 24'h030000, 0, 0, 0, 0, 24'h040000));
    // zero-length edge and fully degenerate triangles
    send_triangle(make_tri(5, 7, 9, 5, 7, 9, 24'h020000, 3, 1));
    send_triangle(make_tri(24'hfffffe, 4, 4, 24'hfffffe, 4, 4, 24'hfffffe, 4, 4));
    send_triangle(make_tri(0, 0, 0, 24'h010000, 24'h010000, 24'h010000,
                           24'h020000, 24'h020000, 24'h020000));
    // barycenter rounding, positive and negative sums
    send_triangle(make_tri(1, 2, 24'hffffff, 0, 0, 24'hffffff, 0, 0, 24'hfffffe));
    send_triangle(make_tri(24'hffffff, 1, 2, 24'hffffff, 0, 2, 24'hfffffe, 0, 0));
    send_triangle(make_tri(1, 1, 1, 1, 1, 1, 1, 1, 24'hfffffd));
    send_triangle(make_tri(CMAX, 0, CMIN, CMIN, CMAX, 0, 0, CMIN, CMAX));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = ((n / 150) % 4 == 2);
      if (n == RANDOM_ITEMS / 2) begin
        // hold off until the pipeline has drained
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      send_triangle(random_triangle());
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (80) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
